// File: rtl/gla_pkg.sv
// Shared widths, register indexes and reset values for the gas level filter alarm.
package gla_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 8;
    localparam int GAIN_SHIFT    = 8;
    localparam int VALUE_BITS    = SAMPLE_BITS + FRACTION_BITS;
    localparam int GAIN_BITS     = 9;
    localparam int SPER_BITS     = 10;
    localparam int BPER_BITS     = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ALARM_ON  = 3'd0,
        CFG_ALARM_OFF = 3'd1,
        CFG_GAIN      = 3'd2,
        CFG_SPER      = 3'd3,
        CFG_BPER      = 3'd4
    } cfg_idx_t;

    localparam logic [SAMPLE_BITS-1:0] ALARM_ON_RST  = SAMPLE_BITS'(1600);
    localparam logic [SAMPLE_BITS-1:0] ALARM_OFF_RST = SAMPLE_BITS'(1400);
    localparam logic [GAIN_BITS-1:0]   GAIN_RST      = GAIN_BITS'(102);
    localparam logic [SPER_BITS-1:0]   SPER_RST      = SPER_BITS'(50);
    localparam logic [BPER_BITS-1:0]   BPER_RST      = BPER_BITS'(300);

endpackage

// File: rtl/gas_level_filter_alarm.sv
// Gas level filter: exponential moving average, hysteresis alarm and blinking indicator drive.
//
// Usage:
//   s_valid/s_ready carry one request per millisecond tick with the sensor sample.
//   m_valid/m_ready return one result per request: the filtered level, the
//   alarm flag, red/green LED drive, buzzer enable and a filter step marker.
//   cfg_valid/cfg_ready write register cfg_index with cfg_data; cfg_ready is
//   always high and unknown indexes are ignored. Write only while idle.
// Timing:
//   A request accepted into the input register has its result loaded into the
//   output register once that register is free or its result is being taken,
//   and m_valid rises with it. Throughput is one request per cycle while
//   m_ready stays high, set by the combinational multiply-add between the two
//   registers.
// Reset (aresetn low, synchronous): registers return to their default levels,
//   the filter is unseeded, the alarm and red LED are off, counters are zero.
// Stall: while m_ready is low the result holds; the input register still
//   takes one more request, then s_ready drops until the result is taken.
module gas_level_filter_alarm (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gla_pkg::SAMPLE_BITS-1:0]   s_sensor_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gla_pkg::SAMPLE_BITS-1:0]   m_filtered_level,
    output logic                              m_alarm_active,
    output logic                              m_red_led,
    output logic                              m_ok_led,
    output logic                              m_buzzer_on,
    output logic                              m_filter_updated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gla_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [gla_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import gla_pkg::*;

    localparam int PROD_BITS = VALUE_BITS + 1 + GAIN_BITS + 1;
    localparam int STEP_BITS = PROD_BITS - GAIN_SHIFT;
    localparam int SUM_BITS  = STEP_BITS + 1;

    logic [SAMPLE_BITS-1:0] on_level_reg, off_level_reg;
    logic [GAIN_BITS-1:0]   gain_reg;
    logic [SPER_BITS-1:0]   sper_reg;
    logic [BPER_BITS-1:0]   bper_reg;

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    logic [VALUE_BITS-1:0]  value_reg, value_next;
    logic                   seeded_reg;
    logic                   alarm_reg, alarm_next;
    logic                   red_reg, red_next;
    logic [SPER_BITS-1:0]   scnt_reg, scnt_next;
    logic [BPER_BITS-1:0]   bcnt_reg, bcnt_next;
    logic                   updated_next;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_level_reg;
    logic                   out_alarm_reg, out_red_reg, out_upd_reg;

    logic                   advance;
    logic [SPER_BITS-1:0]   scnt_inc;
    logic [BPER_BITS-1:0]   bcnt_inc;
    logic [VALUE_BITS-1:0]  target;
    logic signed [VALUE_BITS:0] diff;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [STEP_BITS-1:0] step;
    logic signed [SUM_BITS-1:0]  sum;
    logic [VALUE_BITS-1:0]  stepped;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_level_reg  <= ALARM_ON_RST;
            off_level_reg <= ALARM_OFF_RST;
            gain_reg      <= GAIN_RST;
            sper_reg      <= SPER_RST;
            bper_reg      <= BPER_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ALARM_ON:  on_level_reg  <= cfg_data[SAMPLE_BITS-1:0];
                CFG_ALARM_OFF: off_level_reg <= cfg_data[SAMPLE_BITS-1:0];
                CFG_GAIN:      gain_reg      <= cfg_data[GAIN_BITS-1:0];
                CFG_SPER:      sper_reg      <= cfg_data[SPER_BITS-1:0];
                CFG_BPER:      bper_reg      <= cfg_data[BPER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Filter step: value + floor(gain * (target - value) / 2^GAIN_SHIFT), clamped
    always_comb begin
        target  = {in_sample_reg, {FRACTION_BITS{1'b0}}};
        diff    = $signed({1'b0, target}) - $signed({1'b0, value_reg});
        prod    = PROD_BITS'(diff) * $signed({1'b0, gain_reg});
        step    = STEP_BITS'(prod >>> GAIN_SHIFT);
        sum     = $signed(SUM_BITS'({1'b0, value_reg})) + SUM_BITS'(step);
        if (sum < 0) begin
            stepped = '0;
        end else if (sum[SUM_BITS-1:VALUE_BITS] != '0) begin
            stepped = '1;
        end else begin
            stepped = sum[VALUE_BITS-1:0];
        end
    end

    always_comb begin
        scnt_inc     = (scnt_reg == '1) ? scnt_reg : scnt_reg + 1'b1;
        bcnt_inc     = (bcnt_reg == '1) ? bcnt_reg : bcnt_reg + 1'b1;
        value_next   = value_reg;
        scnt_next    = scnt_reg;
        bcnt_next    = bcnt_reg;
        updated_next = 1'b0;
        if (!seeded_reg) begin
            value_next = target;
        end else begin
            scnt_next = scnt_inc;
            bcnt_next = bcnt_inc;
            if (scnt_inc >= sper_reg) begin
                value_next   = stepped;
                scnt_next    = '0;
                updated_next = 1'b1;
            end
        end

        alarm_next = alarm_reg;
        if (value_next > {on_level_reg, {FRACTION_BITS{1'b0}}}) begin
            alarm_next = 1'b1;
        end else if (value_next < {off_level_reg, {FRACTION_BITS{1'b0}}}) begin
            alarm_next = 1'b0;
        end

        red_next = 1'b0;
        if (alarm_next) begin
            red_next = red_reg;
            if (bcnt_next >= bper_reg) begin
                bcnt_next = '0;
                red_next  = !red_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            seeded_reg    <= 1'b0;
            alarm_reg     <= 1'b0;
            red_reg       <= 1'b0;
            scnt_reg      <= '0;
            bcnt_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                value_reg     <= value_next;
                seeded_reg    <= 1'b1;
                alarm_reg     <= alarm_next;
                red_reg       <= red_next;
                scnt_reg      <= scnt_next;
                bcnt_reg      <= bcnt_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sensor_sample;
        end
        if (advance) begin
            out_level_reg <= value_next[VALUE_BITS-1:FRACTION_BITS];
            out_alarm_reg <= alarm_next;
            out_red_reg   <= red_next;
            out_upd_reg   <= updated_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_filtered_level = out_level_reg;
    assign m_alarm_active   = out_alarm_reg;
    assign m_red_led        = out_red_reg;
    assign m_ok_led         = !out_alarm_reg;
    assign m_buzzer_on      = out_red_reg;
    assign m_filter_updated = out_upd_reg;

    a_red_needs_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        red_reg |-> alarm_reg)
        else $error("red LED lit without alarm");

    a_first_not_updated: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !seeded_reg) |=> (m_valid && !m_filter_updated))
        else $error("seeding request reported a filter step");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_valid_reg && seeded_reg))
        else $error("output register not loaded after advance");

    a_stall_holds_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_sample_reg)))
        else $error("input register lost a stalled request");

    a_updated_clears_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && updated_next) |=> (scnt_reg == '0))
        else $error("sample counter not cleared after filter step");

endmodule

// File: tb/gas_level_filter_alarm_checker.sv
// Checker for the gas level filter alarm: tracks filter, alarm and blink state and compares results.
module gas_level_filter_alarm_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [gla_pkg::SAMPLE_BITS-1:0]   s_sensor_sample,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [gla_pkg::SAMPLE_BITS-1:0]   m_filtered_level,
    input  logic                              m_alarm_active,
    input  logic                              m_red_led,
    input  logic                              m_ok_led,
    input  logic                              m_buzzer_on,
    input  logic                              m_filter_updated,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [gla_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [gla_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                mismatches,
    output int                                pending,
    output int                                results_seen,
    output int                                alarm_results,
    output int                                filter_steps,
    output int                                red_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import gla_pkg::*;

    localparam longint VALUE_TOP    = (longint'(1) << VALUE_BITS) - 1;
    localparam int     REPORT_LIMIT = 100;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] level;
        logic                   alarm;
        logic                   red;
        logic                   green;
        logic                   buzzer;
        logic                   updated;
    } reading_t;

    reading_t expected_readings[$];

    logic [SAMPLE_BITS-1:0] on_level;
    logic [SAMPLE_BITS-1:0] off_level;
    logic [GAIN_BITS-1:0]   gain;
    logic [SPER_BITS-1:0]   step_period;
    logic [BPER_BITS-1:0]   flash_period;

    logic [VALUE_BITS-1:0]  ema_q;
    logic                   seeded;
    logic                   alarm_q;
    logic                   red_q;
    logic [SPER_BITS-1:0]   step_count;
    logic [BPER_BITS-1:0]   flash_count;

    int errors;
    int n_results;
    int n_alarm;
    int n_steps;
    int n_red;

    function automatic reading_t advance_tick(input logic [SAMPLE_BITS-1:0] sample);
        reading_t r;
        longint   delta;
        longint   next;
        logic     stepped;
        stepped = 1'b0;
        if (!seeded) begin
            ema_q  = {sample, {FRACTION_BITS{1'b0}}};
            seeded = 1'b1;
        end else begin
            if (step_count != '1)
                step_count++;
            if (flash_count != '1)
                flash_count++;
            if (step_count >= step_period) begin
                delta = longint'({sample, {FRACTION_BITS{1'b0}}}) - longint'(ema_q);
                next  = longint'(ema_q) + ((longint'(gain) * delta) >>> GAIN_SHIFT);
                if (next < 0)
                    next = 0;
                if (next > VALUE_TOP)
                    next = VALUE_TOP;
                ema_q      = next[VALUE_BITS-1:0];
                step_count = '0;
                stepped    = 1'b1;
            end
        end

        // set test wins when both thresholds hold
        if (ema_q > {on_level, {FRACTION_BITS{1'b0}}})
            alarm_q = 1'b1;
        else if (ema_q < {off_level, {FRACTION_BITS{1'b0}}})
            alarm_q = 1'b0;

        if (alarm_q) begin
            if (flash_count >= flash_period) begin
                flash_count = '0;
                red_q       = ~red_q;
            end
        end else begin
            red_q = 1'b0;
        end

        r.level   = ema_q[VALUE_BITS-1:FRACTION_BITS];
        r.alarm   = alarm_q;
        r.red     = red_q;
        r.green   = ~alarm_q;
        r.buzzer  = red_q;
        r.updated = stepped;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : monitor
        reading_t want;
        if (!aresetn) begin
            on_level     = ALARM_ON_RST;
            off_level    = ALARM_OFF_RST;
            gain         = GAIN_RST;
            step_period  = SPER_RST;
            flash_period = BPER_RST;
            ema_q        = '0;
            seeded       = 1'b0;
            alarm_q      = 1'b0;
            red_q        = 1'b0;
            step_count   = '0;
            flash_count  = '0;
            errors       = 0;
            n_results    = 0;
            n_alarm      = 0;
            n_steps      = 0;
            n_red        = 0;
            expected_readings.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ALARM_ON:  on_level     = cfg_data[SAMPLE_BITS-1:0];
                    CFG_ALARM_OFF: off_level    = cfg_data[SAMPLE_BITS-1:0];
                    CFG_GAIN:      gain         = cfg_data[GAIN_BITS-1:0];
                    CFG_SPER:      step_period  = cfg_data[SPER_BITS-1:0];
                    CFG_BPER:      flash_period = cfg_data[BPER_BITS-1:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                n_results++;
                if (expected_readings.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result with no request pending, %s %0d",
                                 $time, "expected none, got level", m_filtered_level);
                end else begin
                    want = expected_readings.pop_front();
                    check_field("filtered_level", want.level, m_filtered_level);
                    check_field("alarm_active", want.alarm, m_alarm_active);
                    check_field("red_led", want.red, m_red_led);
                    check_field("ok_led", want.green, m_ok_led);
                    check_field("buzzer_on", want.buzzer, m_buzzer_on);
                    check_field("filter_updated", want.updated, m_filter_updated);
                    if (want.alarm)
                        n_alarm++;
                    if (want.updated)
                        n_steps++;
                    if (want.red)
                        n_red++;
                end
            end

            if (s_valid && s_ready)
                expected_readings.push_back(advance_tick(s_sensor_sample));
        end

        mismatches    <= errors;
        pending       <= expected_readings.size();
        results_seen  <= n_results;
        alarm_results <= n_alarm;
        filter_steps  <= n_steps;
        red_results   <= n_red;
    end

endmodule

// File: tb/gas_level_filter_alarm_tb.sv
// Top of the gas level filter alarm testbench: clock, reset, stimulus, back-pressure and verdict.
module gas_level_filter_alarm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gla_pkg::*;

    localparam int TIMEOUT_NS      = 20_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam int GAIN_UNITY      = 1 << GAIN_SHIFT;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [SAMPLE_BITS-1:0]   s_sensor_sample;
    logic                     m_valid;
    logic                     m_ready;
    logic [SAMPLE_BITS-1:0]   m_filtered_level;
    logic                     m_alarm_active;
    logic                     m_red_led;
    logic                     m_ok_led;
    logic                     m_buzzer_on;
    logic                     m_filter_updated;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     hold_req;

    int mismatches;
    int pending;
    int results_seen;
    int alarm_results;
    int filter_steps;
    int red_results;
    int settings_loaded;
    int trend;

    gas_level_filter_alarm u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sensor_sample  (s_sensor_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_level (m_filtered_level),
        .m_alarm_active   (m_alarm_active),
        .m_red_led        (m_red_led),
        .m_ok_led         (m_ok_led),
        .m_buzzer_on      (m_buzzer_on),
        .m_filter_updated (m_filter_updated),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    gas_level_filter_alarm_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sensor_sample  (s_sensor_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_level (m_filtered_level),
        .m_alarm_active   (m_alarm_active),
        .m_red_led        (m_red_led),
        .m_ok_led         (m_ok_led),
        .m_buzzer_on      (m_buzzer_on),
        .m_filter_updated (m_filter_updated),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .pending          (pending),
        .results_seen     (results_seen),
        .alarm_results    (alarm_results),
        .filter_steps     (filter_steps),
        .red_results      (red_results)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL gas_level_filter_alarm");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int run;
        int pick;
        bit held;
        held     = 1'b0;
        m_ready <= 1'b0;
        forever begin
            if (hold_req && !held) begin
                m_ready <= 1'b0;
                held     = 1'b1;
                run      = HOLD_CYCLES;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    m_ready <= 1'b1;
                    run = $urandom_range(1, 40);
                end else if (pick < 90) begin
                    m_ready <= 1'b0;
                    run = $urandom_range(1, 3);
                end else if (pick < 98) begin
                    m_ready <= 1'b0;
                    run = $urandom_range(4, 20);
                end else begin
                    m_ready <= 1'b0;
                    run = $urandom_range(40, 120);
                end
            end
            repeat (run) @(posedge aclk);
        end
    end

    function automatic int pick_gap(input bit busy);
        int pick;
        pick = $urandom_range(0, 99);
        if (busy || pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    // drifting level with noise, occasional jumps, rails and wild readings
    function automatic int next_sample();
        int v;
        if ($urandom_range(0, 39) == 0)
            trend = $urandom_range(0, SAMPLE_MAX);
        case ($urandom_range(0, 49))
            0:       v = 0;
            1:       v = SAMPLE_MAX;
            2, 3:    v = $urandom_range(0, SAMPLE_MAX);
            default: v = trend + $urandom_range(0, 400) - 200;
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v;
    endfunction

    task automatic send_sample(input int sample, input int gap);
        s_valid         <= 1'b1;
        s_sensor_sample <= SAMPLE_BITS'(sample);
        do @(posedge aclk); while (!s_ready);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_settings(input int on_lvl,
                                 input int off_lvl,
                                 input int gain_word,
                                 input int sper,
                                 input int bper);
        s_valid <= 1'b0;
        wait_idle();
        write_reg(CFG_ALARM_ON, CFG_DATA_BITS'(on_lvl));
        write_reg(CFG_ALARM_OFF, CFG_DATA_BITS'(off_lvl));
        write_reg(CFG_GAIN, CFG_DATA_BITS'(gain_word));
        write_reg(CFG_SPER, CFG_DATA_BITS'(sper));
        write_reg(CFG_BPER, CFG_DATA_BITS'(bper));
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    initial begin : stimulus
        int ph;
        int on_lvl;
        int off_lvl;
        int gain_word;
        bit busy;

        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_sensor_sample <= '0;
        cfg_valid       <= 1'b0;
        cfg_index       <= CFG_ALARM_ON;
        cfg_data        <= '0;
        hold_req        <= 1'b0;
        settings_loaded  = 0;
        trend            = SAMPLE_MAX / 2;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: seed at full scale, then drop
        send_sample(SAMPLE_MAX, 0);
        send_sample(0, 1);
        send_sample(0, 0);
        send_sample(SAMPLE_MAX / 2, 2);

        // step and blink every tick, gain overshoots to both rails; stray indexes ignored
        s_valid <= 1'b0;
        wait_idle();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, 12'hAAA);
        cfg_valid <= 1'b0;
        load_settings(int'(ALARM_ON_RST), int'(ALARM_OFF_RST), '1, 0, 0);
        send_sample(0, 0);
        send_sample(SAMPLE_MAX, 0);
        send_sample(0, 1);
        send_sample(SAMPLE_MAX, 0);
        send_sample(1, 0);
        send_sample(SAMPLE_MAX - 1, 3);

        // on level below off level, frozen filter
        load_settings(0, SAMPLE_MAX, 0, 1, 1);
        send_sample(0, 0);
        send_sample(SAMPLE_MAX, 0);
        send_sample(0, 0);

        // unity gain tracks the sample; level sits exactly on the on threshold
        load_settings(SAMPLE_MAX, 0, GAIN_UNITY, 1, 1);
        send_sample(SAMPLE_MAX, 0);
        send_sample(SAMPLE_MAX, 0);
        send_sample(0, 1);
        send_sample(2048, 0);

        load_settings(2000, 1000, GAIN_UNITY / 2, 2, 3);
        repeat (8) send_sample($urandom_range(1500, SAMPLE_MAX), pick_gap(1'b0));

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: load_settings(int'(ALARM_ON_RST), int'(ALARM_OFF_RST), int'(GAIN_RST),
                                 int'(SPER_RST), int'(BPER_RST));
                2: load_settings(0, 0, GAIN_UNITY, '1, '1);
                4: begin
                    on_lvl  = $urandom_range(500, 2000);
                    off_lvl = on_lvl + $urandom_range(1, 1500);
                    load_settings(on_lvl, off_lvl, $urandom_range(1, 511), 0, 0);
                end
                default: begin
                    on_lvl  = $urandom_range(200, 3800);
                    off_lvl = on_lvl - $urandom_range(0, (on_lvl < 600) ? on_lvl : 600);
                    if ($urandom_range(0, 3) == 0)
                        gain_word = $urandom_range(0, (1 << CFG_DATA_BITS) - 1);
                    else
                        gain_word = $urandom_range(20, 300);
                    load_settings(on_lvl, off_lvl, gain_word,
                                  $urandom_range(1, 8), $urandom_range(1, 20));
                end
            endcase
            busy = (ph % 2 == 1);
            if (ph == 3)
                hold_req <= 1'b1;
            repeat (ITEMS_PER_PHASE) send_sample(next_sample(), pick_gap(busy));
        end

        s_valid <= 1'b0;
        wait_idle();

        $display("Ran %0d ticks through %0d register settings, rails and zero periods included.",
                 results_seen, settings_loaded);
        $display("Alarm held in %0d results, red lit in %0d, filter stepped %0d times.",
                 alarm_results, red_results, filter_steps);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS gas_level_filter_alarm");
        end else begin
            $display("FAIL gas_level_filter_alarm");
        end
        $finish;
    end

endmodule
